// File: hdl/delta_list_timer_queue_macros.svh
// Assertion helpers for the timer queue checker
`ifndef DELTA_LIST_TIMER_QUEUE_MACROS_SVH
`define DELTA_LIST_TIMER_QUEUE_MACROS_SVH
// Implication checked on every clock edge outside reset
`define DLTQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Implication checked on every edge, including reset
`define DLTQ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: hdl/dltq_pkg.sv
`default_nettype none
package dltq_pkg;
   localparam int ActionW = 2;
   localparam int KindW   = 3;
   localparam logic [ActionW-1:0] ACT_INSERT = 2'd0;
   localparam logic [ActionW-1:0] ACT_REMOVE = 2'd1;
   localparam logic [ActionW-1:0] ACT_TICK   = 2'd2;
   localparam logic [KindW-1:0] KIND_INSERTED = 3'd0;
   localparam logic [KindW-1:0] KIND_FULL     = 3'd1;
   localparam logic [KindW-1:0] KIND_REMOVED  = 3'd2;
   localparam logic [KindW-1:0] KIND_NOTFOUND = 3'd3;
   localparam logic [KindW-1:0] KIND_WOKEN    = 3'd4;
   localparam logic [KindW-1:0] KIND_IDLE     = 3'd5;

   // Controller to datapath commands
   typedef struct packed {
      logic load;      // capture request, reset walk
      logic rd;        // issue memory read of cur
      logic step;      // advance walk (prev<=cur, cur<=next, sub delta)
      logic ins_commit;
      logic rem_commit;
      logic tick_dec;  // decrement head delta (if needed)
      logic wake;      // pop head, emit woken
      logic emit;      // emit summary result
      logic [KindW-1:0] kind;
   } dltq_cmd_type;

   // Datapath status to controller
   typedef struct packed {
      logic cur_ok;      // cur points to a slot
      logic le;          // mem delta <= remaining delay
      logic match;       // mem task == request task
      logic has_free;
      logic head_zero;   // head delta is zero
      logic carry;       // carry_zero flag
      logic full_res;    // results emitted reached limit
      logic out_busy;    // output register holds result
      logic walk_max;    // step count reached limit
      logic [ActionW-1:0] action;
   } dltq_sts_type;
endpackage
`default_nettype wire

// File: hdl/dltq_ctrl.sv
`default_nettype none
module dltq_ctrl (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_fire,
   output logic      req_ready,
   input  wire dltq_pkg::dltq_sts_type sts,
   output dltq_pkg::dltq_cmd_type cmd
);
   import dltq_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE = 8'b00000001,
      S_DISP = 8'b00000010,
      S_RD   = 8'b00000100,
      S_EVAL = 8'b00001000,
      S_TRD  = 8'b00010000,
      S_TDEC = 8'b00100000,
      S_TCHK = 8'b01000000,
      S_DONE = 8'b10000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   assign req_ready = (state_ff == S_IDLE);

   // Sequencer: each memory read is registered before the state that evaluates it
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.kind = KIND_IDLE;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd.load = 1'b1;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            case (sts.action)
               ACT_INSERT: begin
                  if (!sts.has_free) begin
                     if (!sts.out_busy) begin
                        cmd.emit = 1'b1; cmd.kind = KIND_FULL; state_in = S_IDLE;
                     end
                  end else if (sts.cur_ok) begin
                     cmd.rd = 1'b1; state_in = S_EVAL;
                  end else state_in = S_DONE;
               end
               ACT_REMOVE: begin
                  if (sts.cur_ok) begin
                     cmd.rd = 1'b1; state_in = S_EVAL;
                  end else if (!sts.out_busy) begin
                     cmd.emit = 1'b1; cmd.kind = KIND_NOTFOUND; state_in = S_IDLE;
                  end
               end
               ACT_TICK: begin
                  if (!sts.cur_ok) begin
                     if (!sts.out_busy) begin
                        cmd.emit = 1'b1; cmd.kind = KIND_IDLE; state_in = S_IDLE;
                     end
                  end else begin
                     cmd.rd = 1'b1; state_in = S_TDEC;
                  end
               end
               default: begin
                  if (!sts.out_busy) begin
                     cmd.emit = 1'b1; cmd.kind = KIND_IDLE; state_in = S_IDLE;
                  end
               end
            endcase
         end
         S_RD: begin
            if (sts.cur_ok && !sts.walk_max) begin
               cmd.rd = 1'b1; state_in = S_EVAL;
            end else state_in = S_DONE;
         end
         S_EVAL: begin
            if (sts.action == ACT_INSERT) begin
               if (sts.le) begin
                  cmd.step = 1'b1; state_in = S_RD;
               end else state_in = S_DONE;
            end else begin
               if (sts.match) state_in = S_DONE;
               else begin
                  cmd.step = 1'b1; state_in = S_RD;
               end
            end
         end
         S_DONE: begin
            if (!sts.out_busy) begin
               if (sts.action == ACT_INSERT) begin
                  cmd.ins_commit = 1'b1; cmd.emit = 1'b1; cmd.kind = KIND_INSERTED;
               end else if (sts.cur_ok && sts.match) begin
                  cmd.rem_commit = 1'b1; cmd.emit = 1'b1; cmd.kind = KIND_REMOVED;
               end else begin
                  cmd.emit = 1'b1; cmd.kind = KIND_NOTFOUND;
               end
               state_in = S_IDLE;
            end
         end
         S_TDEC: begin
            cmd.tick_dec = 1'b1;
            state_in = S_TCHK;
         end
         S_TRD: begin
            if (sts.cur_ok) begin
               cmd.rd = 1'b1; state_in = S_TCHK;
            end else if (!sts.out_busy) begin
               cmd.emit = 1'b1; cmd.kind = KIND_IDLE; state_in = S_IDLE;
            end
         end
         S_TCHK: begin
            if (!sts.out_busy) begin
               if (sts.head_zero && !sts.full_res) begin
                  cmd.wake = 1'b1; state_in = S_TRD;
               end else begin
                  cmd.emit = 1'b1; cmd.kind = KIND_IDLE; state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// File: hdl/dltq_dpath.sv
`default_nettype none
module dltq_dpath #(
   parameter int MaxEntries = 16,
   parameter int MaxResults = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire dltq_pkg::dltq_cmd_type cmd,
   output dltq_pkg::dltq_sts_type sts,
   input  wire logic [1:0]  req_action,
   input  wire logic [7:0]  req_task,
   input  wire logic [7:0]  req_sem,
   input  wire logic [15:0] req_delay,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_kind,
   output logic [7:0]       rsp_task,
   output logic [7:0]       rsp_sem,
   output logic             rsp_last
);
   import dltq_pkg::*;

   localparam int SW = $clog2(MaxEntries) + 1;  // slot index plus null marker
   localparam int IW = $clog2(MaxEntries);
   localparam int RW = $clog2(MaxResults + 1);
   localparam logic [SW-1:0] NullSlot = SW'(MaxEntries);

   // Entry storage
   logic [7:0]    mem_task  [MaxEntries];
   logic [7:0]    mem_sem   [MaxEntries];
   logic [15:0]   mem_delta [MaxEntries];
   logic [SW-1:0] mem_next  [MaxEntries];

   logic [MaxEntries-1:0] free_ff;
   logic [SW-1:0] head_ff, cur_ff, prev_ff;
   logic carry_ff;
   logic [1:0]  act_ff;
   logic [7:0]  task_ff, sem_ff;
   logic [16:0] d_ff;
   logic [SW-1:0] cnt_ff;
   logic [RW-1:0] nres_ff;
   logic [7:0]  rd_task, rd_sem;
   logic [15:0] rd_delta;
   logic [SW-1:0] rd_next;
   logic [IW-1:0] free_slot;
   logic has_free;
   logic v_ff, last_ff;
   logic [2:0] kind_ff;
   logic [7:0] otask_ff, osem_ff;
   logic [15:0] rem_delta_sum;
   logic [15:0] nx_delta_ff;
   logic [15:0] hd_ff;
   logic [7:0]  pend_task_ff, pend_sem_ff;

   // Lowest free slot
   always_comb begin
      free_slot = '0;
      has_free = 1'b0;
      for (int i = MaxEntries - 1; i >= 0; i--) begin
         if (free_ff[i]) begin
            free_slot = IW'(i);
            has_free = 1'b1;
         end
      end
   end

   wire cur_ok = (cur_ff < NullSlot);
   wire prev_ok = (prev_ff < NullSlot);
   wire [IW-1:0] cur_i = cur_ff[IW-1:0];
   wire [IW-1:0] prev_i = prev_ff[IW-1:0];

   // Registered memory read of the walk pointer
   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rd_task  <= mem_task[cur_i];
         rd_sem   <= mem_sem[cur_i];
         rd_delta <= mem_delta[cur_i];
         rd_next  <= mem_next[cur_i];
      end
   end

   wire [SW-1:0] nx_clean = (rd_next < NullSlot) ? rd_next : NullSlot;

   // Memory writes
   always_ff @(posedge clock) begin
      if (cmd.ins_commit) begin
         mem_task[free_slot]  <= task_ff;
         mem_sem[free_slot]   <= sem_ff;
         mem_delta[free_slot] <= d_ff[15:0];
         mem_next[free_slot]  <= cur_ok ? cur_ff : NullSlot;
         if (prev_ok) mem_next[prev_i] <= {1'b0, free_slot};
         if (cur_ok) mem_delta[cur_i] <= rd_delta - d_ff[15:0];
      end else if (cmd.rem_commit) begin
         if (nx_clean < NullSlot) mem_delta[nx_clean[IW-1:0]] <= rem_delta_sum;
         if (prev_ok) mem_next[prev_i] <= nx_clean;
      end else if (cmd.tick_dec) begin
         if (!(carry_ff && rd_delta == 16'd0)) mem_delta[cur_i] <= rd_delta - 16'd1;
      end
   end

   // Successor delta, read in the cycle after the entry itself
   always_ff @(posedge clock) begin
      if (nx_clean < NullSlot) nx_delta_ff <= mem_delta[nx_clean[IW-1:0]];
   end
   assign rem_delta_sum = nx_delta_ff + rd_delta;

   // Tick decrement visible to the check stage
   always_ff @(posedge clock) begin
      if (cmd.tick_dec) hd_ff <= (carry_ff && rd_delta == 16'd0) ? 16'd0 : rd_delta - 16'd1;
      else if (cmd.rd) hd_ff <= mem_delta[cur_i];
   end

   // Walk and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff  <= '1;
         head_ff  <= NullSlot;
         carry_ff <= 1'b0;
         cur_ff   <= NullSlot;
         prev_ff  <= NullSlot;
      end else begin
         if (cmd.load) begin
            act_ff  <= req_action;
            task_ff <= req_task;
            sem_ff  <= req_sem;
            d_ff    <= (req_delay == 16'd0) ? 17'd1 : {1'b0, req_delay};
            cur_ff  <= head_ff;
            prev_ff <= NullSlot;
            cnt_ff  <= '0;
            nres_ff <= '0;
         end
         if (cmd.step) begin
            if (act_ff == ACT_INSERT) d_ff <= d_ff - {1'b0, rd_delta};
            prev_ff <= cur_ff;
            cur_ff  <= nx_clean;
            cnt_ff  <= cnt_ff + SW'(1);
         end
         if (cmd.ins_commit) begin
            free_ff[free_slot] <= 1'b0;
            if (!prev_ok) head_ff <= {1'b0, free_slot};
         end
         if (cmd.rem_commit) begin
            free_ff[cur_i] <= 1'b1;
            if (!prev_ok) head_ff <= nx_clean;
         end
         if (cmd.tick_dec) carry_ff <= 1'b0;
         if (cmd.wake) begin
            free_ff[cur_i] <= 1'b1;
            head_ff <= nx_clean;
            cur_ff  <= nx_clean;
            nres_ff <= nres_ff + RW'(1);
         end
         if (act_ff == ACT_TICK && cmd.emit && nres_ff == RW'(MaxResults) && cur_ok
             && hd_ff == 16'd0)
            carry_ff <= 1'b1;
         if (cmd.emit && act_ff == ACT_TICK && !cur_ok) carry_ff <= 1'b0;
      end
   end

   // Woken entry held back until it is known whether it closes the run
   always_ff @(posedge clock) begin
      if (cmd.wake) begin
         pend_task_ff <= rd_task;
         pend_sem_ff  <= rd_sem;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) v_ff <= 1'b0;
      else if (cmd.emit || (cmd.wake && nres_ff != '0)) v_ff <= 1'b1;
      else if (rsp_ready) v_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.wake && nres_ff != '0) begin
         kind_ff <= KIND_WOKEN; otask_ff <= pend_task_ff; osem_ff <= pend_sem_ff;
         last_ff <= 1'b0;
      end else if (cmd.emit) begin
         last_ff <= 1'b1;
         if (act_ff == ACT_TICK && nres_ff != '0) begin
            // close the run of woken results
            kind_ff <= KIND_WOKEN; otask_ff <= pend_task_ff; osem_ff <= pend_sem_ff;
         end else begin
            kind_ff <= cmd.kind; osem_ff <= 8'd0;
            if (act_ff == ACT_TICK) otask_ff <= cur_ok ? rd_task : 8'd0;
            else if (act_ff == ACT_INSERT || act_ff == ACT_REMOVE) otask_ff <= task_ff;
            else otask_ff <= 8'd0;
         end
      end
   end

   assign rsp_valid = v_ff;
   assign rsp_kind  = kind_ff;
   assign rsp_task  = otask_ff;
   assign rsp_sem   = osem_ff;
   assign rsp_last  = last_ff;

   always_comb begin
      sts = '0;
      sts.cur_ok    = cur_ok;
      sts.le        = ({1'b0, rd_delta} <= d_ff);
      sts.match     = (rd_task == task_ff);
      sts.has_free  = has_free;
      sts.head_zero = (hd_ff == 16'd0);
      sts.carry     = carry_ff;
      sts.full_res  = (nres_ff == RW'(MaxResults));
      sts.out_busy  = v_ff && !rsp_ready;
      sts.walk_max  = (cnt_ff >= SW'(MaxEntries));
      sts.action    = act_ff;
   end
endmodule
`default_nettype wire

// File: hdl/delta_list_timer_queue.sv
// Channel | Port group | Fields (low bit first)
// input   | req_       | tdata: action[1:0] task_id[9:2] sem_id[17:10] delay[33:18]
// output  | rsp_       | tdata: kind[2:0] woken_task[10:3] woken_sem[18:11]; tlast: last
// Insert and remove walk the linked list one entry at a time, each a registered memory
// read, then a compare; a tick reads the head, decrements its delta and wakes entries
// while the head delta is zero. Each woken result leaves one wake step late.
// One request is worked at a time; req_tready is high only while idle.
// Synchronous reset empties the list at once; no clearing pass.
// A stalled rsp_ holds the sequencer at each step that emits or wakes until the result is taken.
`default_nettype none
module delta_list_timer_queue #(
   parameter int MAX_ENTRIES = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // action, task_id, sem_id, delay
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,  // kind, woken_task, woken_sem
   output logic             rsp_tlast   // last
);
   import dltq_pkg::*;

   dltq_cmd_type cmd;
   dltq_sts_type sts;
   logic [2:0] kind;
   logic [7:0] otask, osem;

   dltq_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_fire(req_tvalid && req_tready),
      .req_ready(req_tready),
      .sts(sts), .cmd(cmd)
   );

   dltq_dpath #(.MaxEntries(MAX_ENTRIES), .MaxResults(16)) u_dpath (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_action(req_tdata[1:0]), .req_task(req_tdata[9:2]),
      .req_sem(req_tdata[17:10]), .req_delay(req_tdata[33:18]),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready),
      .rsp_kind(kind), .rsp_task(otask), .rsp_sem(osem), .rsp_last(rsp_tlast)
   );

   assign rsp_tdata = {5'd0, osem, otask, kind};
endmodule
`default_nettype wire

// File: hdl/dltq_checker.sv
`default_nettype none
`include "delta_list_timer_queue_macros.svh"
module dltq_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic        rsp_tlast
);
   import dltq_pkg::*;

   wire [KindW-1:0] rsp_kind = rsp_tdata[2:0];
   wire [7:0]       rsp_sem  = rsp_tdata[18:11];

   `DLTQ_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "rsp dropped")
   `DLTQ_ASSERT(a_sem_zero, clock, reset, rsp_tvalid && rsp_kind != KIND_WOKEN |-> rsp_sem == 8'd0, "sem nonzero")
   `DLTQ_ASSERT(a_last_set, clock, reset, rsp_tvalid && rsp_kind != KIND_WOKEN |-> rsp_tlast, "last missing")
   `DLTQ_ASSERT(a_one_req, clock, reset, req_tvalid && req_tready |=> !req_tready, "second request taken")
   `DLTQ_ASSERT_ALWAYS(a_rst, clock, reset |=> !rsp_tvalid, "rsp after reset")
endmodule
bind delta_list_timer_queue dltq_checker u_chk (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tlast(rsp_tlast)
);
`default_nettype wire
